[src/vckd_pkg.sv]
`default_nettype none
package vckd_pkg;

  localparam int FIFO_DEPTH    = 16;
  localparam int NUM_TERMINALS = 4;

  localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W    = $clog2(FIFO_DEPTH + 1);
  localparam int TIDX_W    = (NUM_TERMINALS > 1) ? $clog2(NUM_TERMINALS) : 1;
  localparam int MEM_DEPTH = NUM_TERMINALS * FIFO_DEPTH;
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int QDEPTH    = 2;
  localparam int QIDX_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [7:0] KEY_ESC = 8'h1B;
  localparam logic [7:0] KEY_O   = 8'h4F;
  localparam logic [7:0] KEY_F1  = 8'h50;
  localparam logic [7:0] KEY_F4  = 8'h53;

  localparam logic [1:0] OP_RX     = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_SELECT = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_POP  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [1:0] terminal;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [1:0] active_terminal;
    logic       switched;
    logic       byte_dropped;
    logic       key_pending;
  } out_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [1:0] term;
    logic [7:0] data;
    logic [1:0] active_terminal;
    logic       switched;
    logic       key_pending;
  } cmd_t;

  function automatic logic term_ok(input logic [1:0] t);
    return (32'(t) < NUM_TERMINALS);
  endfunction

endpackage
`default_nettype wire

[src/vckd_front.sv]
`default_nettype none
module vckd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire vckd_pkg::in_t  item,
  input  wire logic           fire,
  output vckd_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    DET_IDLE = 3'b001,
    DET_ESC  = 3'b010,
    DET_ESCO = 3'b100
  } det_t;

  det_t       det_r, det_nxt;
  logic [1:0] cur_r, cur_nxt;
  logic [1:0] key_term;
  logic       is_fkey;
  logic       pend;
  logic       key_hit;

  assign key_term = 2'(item.rx_byte - vckd_pkg::KEY_F1);
  assign is_fkey  = (item.rx_byte >= vckd_pkg::KEY_F1) && (item.rx_byte <= vckd_pkg::KEY_F4);

  // prefix detector
  always_comb begin
    det_nxt = det_r;
    pend    = 1'b0;
    key_hit = 1'b0;
    unique case (det_r)
      DET_IDLE: begin
        if (item.rx_byte == vckd_pkg::KEY_ESC) begin
          det_nxt = DET_ESC;
          pend    = 1'b1;
        end
      end
      DET_ESC: begin
        if (item.rx_byte == vckd_pkg::KEY_O) begin
          det_nxt = DET_ESCO;
          pend    = 1'b1;
        end else begin
          det_nxt = DET_IDLE;
        end
      end
      DET_ESCO: begin
        det_nxt = DET_IDLE;
        key_hit = is_fkey;
      end
      default: begin
        det_nxt = DET_IDLE;
      end
    endcase
  end

  always_comb begin
    cur_nxt          = cur_r;
    cmd.kind         = vckd_pkg::CMD_NONE;
    cmd.term         = cur_r;
    cmd.data         = item.rx_byte;
    cmd.switched     = 1'b0;
    cmd.key_pending  = 1'b0;
    unique case (item.operation)
      vckd_pkg::OP_RX: begin
        if (pend) begin
          cmd.key_pending = 1'b1;
        end else if (key_hit) begin
          if (vckd_pkg::term_ok(key_term) && key_term != cur_r) begin
            cur_nxt      = key_term;
            cmd.switched = 1'b1;
          end
        end else if (vckd_pkg::term_ok(cur_r)) begin
          cmd.kind = vckd_pkg::CMD_PUSH;
        end
      end
      vckd_pkg::OP_READ: begin
        cmd.term = item.terminal;
        if (vckd_pkg::term_ok(item.terminal)) begin
          cmd.kind = vckd_pkg::CMD_POP;
        end
      end
      vckd_pkg::OP_SELECT: begin
        if (vckd_pkg::term_ok(item.terminal) && item.terminal != cur_r) begin
          cur_nxt      = item.terminal;
          cmd.switched = 1'b1;
        end
      end
      vckd_pkg::OP_NONE: begin
        cmd.kind = vckd_pkg::CMD_NONE;
      end
      default: begin
        cmd.kind = vckd_pkg::CMD_NONE;
      end
    endcase
    cmd.active_terminal = cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_r <= DET_IDLE;
      cur_r <= 2'd0;
    end else if (fire) begin
      cur_r <= cur_nxt;
      if (item.operation == vckd_pkg::OP_RX) begin
        det_r <= det_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[src/vckd_queue.sv]
`default_nettype none
module vckd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire vckd_pkg::cmd_t push_cmd,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output vckd_pkg::cmd_t      pop_cmd
);

  vckd_pkg::cmd_t                  ent_r [vckd_pkg::QDEPTH];
  logic [vckd_pkg::QIDX_W-1:0]     wr_r;
  logic [vckd_pkg::QIDX_W-1:0]     rd_r;
  logic [vckd_pkg::QCNT_W-1:0]     cnt_r;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (cnt_r != vckd_pkg::QCNT_W'(vckd_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = ent_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[src/vckd_back.sv]
`default_nettype none
module vckd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire vckd_pkg::cmd_t cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output vckd_pkg::out_t      out_data
);

  logic [7:0]                   mem [vckd_pkg::MEM_DEPTH];
  logic [vckd_pkg::PTR_W-1:0]   wptr_r [vckd_pkg::NUM_TERMINALS];
  logic [vckd_pkg::PTR_W-1:0]   rptr_r [vckd_pkg::NUM_TERMINALS];
  logic [vckd_pkg::FILL_W-1:0]  fill_r [vckd_pkg::NUM_TERMINALS];

  logic                         out_valid_r;
  logic [7:0]                   rdata_r;
  logic                         rvalid_r;
  logic [1:0]                   act_r;
  logic                         sw_r;
  logic                         drop_r;
  logic                         pend_r;

  logic [vckd_pkg::TIDX_W-1:0]  tidx;
  logic [vckd_pkg::PTR_W-1:0]   wptr;
  logic [vckd_pkg::PTR_W-1:0]   rptr;
  logic [vckd_pkg::FILL_W-1:0]  fill;
  logic [vckd_pkg::ADDR_W-1:0]  base;
  logic                         take;
  logic                         do_wr;
  logic                         do_rd;

  assign cmd_ready = !out_valid_r || out_ready;
  assign take      = cmd_valid && cmd_ready;
  assign tidx      = cmd.term[vckd_pkg::TIDX_W-1:0];
  assign wptr      = wptr_r[tidx];
  assign rptr      = rptr_r[tidx];
  assign fill      = fill_r[tidx];
  assign base      = vckd_pkg::ADDR_W'(32'(tidx) * vckd_pkg::FIFO_DEPTH);
  assign do_wr     = take && (cmd.kind == vckd_pkg::CMD_PUSH)
                     && (fill < vckd_pkg::FILL_W'(vckd_pkg::FIFO_DEPTH));
  assign do_rd     = take && (cmd.kind == vckd_pkg::CMD_POP) && (fill != '0);

  // ring fifo storage, all terminals share one array
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[base + vckd_pkg::ADDR_W'(wptr)] <= cmd.data;
    end
    if (do_rd) begin
      rdata_r <= mem[base + vckd_pkg::ADDR_W'(rptr)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vckd_pkg::NUM_TERMINALS; i++) begin
        wptr_r[i] <= '0;
        rptr_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      if (do_wr) begin
        wptr_r[tidx] <= (32'(wptr) == vckd_pkg::FIFO_DEPTH - 1) ? '0 : wptr + 1'b1;
        fill_r[tidx] <= fill + 1'b1;
      end
      if (do_rd) begin
        rptr_r[tidx] <= (32'(rptr) == vckd_pkg::FIFO_DEPTH - 1) ? '0 : rptr + 1'b1;
        fill_r[tidx] <= fill - 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_ready) begin
      out_valid_r <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rvalid_r <= do_rd;
      act_r    <= cmd.active_terminal;
      sw_r     <= cmd.switched;
      drop_r   <= (cmd.kind == vckd_pkg::CMD_PUSH) && !do_wr;
      pend_r   <= cmd.key_pending;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_data.read_data       = rvalid_r ? rdata_r : 8'd0;
  assign out_data.read_valid      = rvalid_r;
  assign out_data.active_terminal = act_r;
  assign out_data.switched        = sw_r;
  assign out_data.byte_dropped    = drop_r;
  assign out_data.key_pending     = pend_r;

endmodule
`default_nettype wire

[src/virtual_console_key_demux_core.sv]
`default_nettype none
// keyboard demultiplexer for virtual terminals. a front stage runs the esc-o-p..s
// detector and tracks the active terminal, a two-beat command queue decouples it
// from a back stage holding one 16-byte ring fifo per terminal in a shared memory.
// one beat is taken per cycle while in_ready is high; each result passes through
// the queue entry, then the fifo memory read into the result register. the queue
// holds two beats and the result register one, so under output backpressure
// in_ready drops once all three are filled; at full rate the queue holds one beat
// and in_ready drops in the cycle after out_ready does. reads of an empty fifo or
// an unused terminal return zero with read_valid low; fifo contents need no reset
// since only filled entries pop.
module virtual_console_key_demux_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire vckd_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output vckd_pkg::out_t      out_data
);

  vckd_pkg::cmd_t front_cmd;
  vckd_pkg::cmd_t q_cmd;
  logic           q_valid;
  logic           q_ready;
  logic           fire;

  assign fire = in_valid && in_ready;

  vckd_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (in_data),
    .fire  (fire),
    .cmd   (front_cmd)
  );

  vckd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  vckd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[sim/key_demux_checker.sv]
module key_demux_checker
  import vckd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire in_t  in_data,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire out_t out_data,
  output int        fail_count,
  output int        beats_outstanding
);

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ESC,
    SEQ_ESC_O
  } seq_state_t;

  seq_state_t seq_state;
  logic [1:0] active_term;
  logic [7:0] ring_mem [NUM_TERMINALS][FIFO_DEPTH];
  int         wr_idx [NUM_TERMINALS];
  int         rd_idx [NUM_TERMINALS];
  int         fill_cnt [NUM_TERMINALS];
  out_t       expected_beats [$];
  out_t       want;

  initial begin
    fail_count = 0;
    beats_outstanding = 0;
  end

  function automatic out_t predict_console_beat(input in_t beat);
    out_t res;
    int   key_term;
    bit   swallowed;
    int   slot;
    res = '0;
    key_term = -1;
    swallowed = 1'b0;
    slot = int'(beat.terminal);
    case (beat.operation)
      OP_RX: begin
        case (seq_state)
          SEQ_IDLE: begin
            if (beat.rx_byte == KEY_ESC) begin
              seq_state = SEQ_ESC;
              swallowed = 1'b1;
            end
          end
          SEQ_ESC: begin
            if (beat.rx_byte == KEY_O) begin
              seq_state = SEQ_ESC_O;
              swallowed = 1'b1;
            end else begin
              seq_state = SEQ_IDLE;
            end
          end
          default: begin
            if (beat.rx_byte >= KEY_F1 && beat.rx_byte <= KEY_F4) begin
              key_term = int'(beat.rx_byte - KEY_F1);
            end
            seq_state = SEQ_IDLE;
          end
        endcase
        if (swallowed) begin
          res.key_pending = 1'b1;
        end else if (key_term >= 0) begin
          if (key_term < NUM_TERMINALS && key_term != int'(active_term)) begin
            active_term = 2'(key_term);
            res.switched = 1'b1;
          end
        end else begin
          // plain byte, including one that broke a prefix
          slot = int'(active_term);
          if (fill_cnt[slot] < FIFO_DEPTH) begin
            ring_mem[slot][wr_idx[slot]] = beat.rx_byte;
            wr_idx[slot] = (wr_idx[slot] + 1) % FIFO_DEPTH;
            fill_cnt[slot]++;
          end else begin
            res.byte_dropped = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (slot < NUM_TERMINALS && fill_cnt[slot] > 0) begin
          res.read_data = ring_mem[slot][rd_idx[slot]];
          res.read_valid = 1'b1;
          rd_idx[slot] = (rd_idx[slot] + 1) % FIFO_DEPTH;
          fill_cnt[slot]--;
        end
      end
      OP_SELECT: begin
        if (slot < NUM_TERMINALS && slot != int'(active_term)) begin
          active_term = beat.terminal;
          res.switched = 1'b1;
        end
      end
      default: ;
    endcase
    res.active_terminal = active_term;
    return res;
  endfunction

  task automatic check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seq_state = SEQ_IDLE;
      active_term = '0;
      for (int i = 0; i < NUM_TERMINALS; i++) begin
        wr_idx[i] = 0;
        rd_idx[i] = 0;
        fill_cnt[i] = 0;
      end
      expected_beats.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, expected none, actual %p",
                   $time, out_data);
        end else begin
          want = expected_beats.pop_front();
          check_field("read_data", want.read_data, out_data.read_data);
          check_field("read_valid", want.read_valid, out_data.read_valid);
          check_field("active_terminal", want.active_terminal, out_data.active_terminal);
          check_field("switched", want.switched, out_data.switched);
          check_field("byte_dropped", want.byte_dropped, out_data.byte_dropped);
          check_field("key_pending", want.key_pending, out_data.key_pending);
        end
      end
      if (in_valid && in_ready) begin
        expected_beats.push_back(predict_console_beat(in_data));
      end
    end
    beats_outstanding <= expected_beats.size();
  end

endmodule

[sim/tb_virtual_console_key_demux_core.sv]
module tb_virtual_console_key_demux_core;
  import vckd_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int RUN_LIMIT  = 500000;
  localparam int RAND_BEATS = 975;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  int          fail_count;
  int          beats_outstanding;
  int          beats_sent;
  bit          sender_gaps;
  bit          long_hold_req;
  int unsigned cycle_count = 0;

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  virtual_console_key_demux_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  key_demux_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .fail_count        (fail_count),
    .beats_outstanding (beats_outstanding)
  );

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [1:0] any_term();
    return 2'($urandom_range(0, 3));
  endfunction

  task automatic send_beat(input logic [1:0] op, input logic [7:0] b, input logic [1:0] t);
    in_t item;
    int  pick;
    int  gap;
    item.operation = op;
    item.rx_byte = b;
    item.terminal = t;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    if (op != OP_NONE) beats_sent++;
    if (sender_gaps) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(6, 25);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_outstanding != 0) @(posedge clk);
  endtask

  task automatic run_traffic();
    int         pick;
    int         n;
    logic [1:0] t;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 34) begin
      send_beat(OP_RX, any_byte(), any_term());
    end else if (pick < 62) begin
      send_beat(OP_READ, any_byte(), any_term());
    end else if (pick < 72) begin
      send_beat(OP_SELECT, any_byte(), any_term());
    end else if (pick < 76) begin
      send_beat(OP_NONE, any_byte(), any_term());
    end else if (pick < 94) begin
      // function key, sometimes broken after esc or after esc o
      send_beat(OP_RX, KEY_ESC, any_term());
      b = ($urandom_range(0, 99) < 85) ? KEY_O : any_byte();
      send_beat(OP_RX, b, any_term());
      if ($urandom_range(0, 99) < 85) b = 8'(KEY_F1 + 8'($urandom_range(0, 3)));
      else b = any_byte();
      send_beat(OP_RX, b, any_term());
    end else begin
      // overfill one terminal, then empty it
      t = any_term();
      n = $urandom_range(FIFO_DEPTH + 1, FIFO_DEPTH + 4);
      send_beat(OP_SELECT, any_byte(), t);
      repeat (n) begin
        b = any_byte();
        if (b == KEY_ESC || b == KEY_O || (b >= KEY_F1 && b <= KEY_F4)) b = b ^ 8'h80;
        send_beat(OP_RX, b, any_term());
      end
      repeat (n) send_beat(OP_READ, any_byte(), t);
    end
  endtask

  initial begin : result_sink
    int len;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        len = 100;
      end else if ($urandom_range(0, 99) < 65) begin
        out_ready <= 1'b1;
        len = $urandom_range(1, 20);
      end else begin
        out_ready <= 1'b0;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      repeat (len) @(posedge clk);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int next_hold;
    bit drained;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    beats_sent = 0;
    sender_gaps = 1'b1;
    long_hold_req = 1'b0;
    next_hold = 300;
    drained = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(OP_READ, any_byte(), 2'd0);
    send_beat(OP_NONE, 8'hFF, 2'd3);
    send_beat(OP_RX, 8'h00, 2'd3);
    send_beat(OP_RX, 8'hFF, 2'd0);
    send_beat(OP_RX, KEY_ESC, any_term());
    send_beat(OP_RX, KEY_O, any_term());
    send_beat(OP_RX, 8'(KEY_F1 + 8'd1), any_term());
    // same key again, already active
    send_beat(OP_RX, KEY_ESC, any_term());
    send_beat(OP_RX, KEY_O, any_term());
    send_beat(OP_RX, 8'(KEY_F1 + 8'd1), any_term());
    send_beat(OP_RX, KEY_ESC, any_term());
    send_beat(OP_RX, 8'h41, any_term());
    send_beat(OP_RX, KEY_ESC, any_term());
    send_beat(OP_RX, KEY_O, any_term());
    send_beat(OP_RX, 8'h54, any_term());
    // read in the middle of a prefix leaves the detector alone
    send_beat(OP_RX, KEY_ESC, any_term());
    send_beat(OP_READ, any_byte(), 2'd1);
    send_beat(OP_RX, KEY_O, any_term());
    send_beat(OP_RX, KEY_F4, any_term());
    send_beat(OP_SELECT, any_byte(), 2'd3);
    send_beat(OP_SELECT, any_byte(), 2'd0);
    send_beat(OP_READ, any_byte(), 2'd1);
    send_beat(OP_READ, any_byte(), 2'd0);
    send_beat(OP_READ, any_byte(), 2'd0);
    send_beat(OP_READ, any_byte(), 2'd2);

    while (beats_sent < RAND_BEATS) begin
      if (beats_sent >= next_hold) begin
        // receiver stalls long while beats keep coming
        in_valid <= 1'b0;
        long_hold_req = 1'b1;
        while (long_hold_req) @(posedge clk);
        sender_gaps = 1'b0;
        repeat (12) run_traffic();
        sender_gaps = 1'b1;
        next_hold = next_hold + 350;
      end else if (!drained && beats_sent >= 550) begin
        drain_results();
        drained = 1'b1;
      end else begin
        run_traffic();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
